// File: sv/lmpm_pkg.sv
// ----------------------------------------------------------------------------
// lmpm_pkg
// Shared types, constants and helpers of the LED matrix pixel mapper:
// default geometry, register indexes, wiring codes and colour scaling.
// ----------------------------------------------------------------------------
package lmpm_pkg;

	// default geometry of the matrix
	localparam int DEF_MATRIX_WIDTH  = 16;
	localparam int DEF_MATRIX_HEIGHT = 7;
	localparam int DEF_LED_COUNT     = 112;

	// field widths
	localparam int COORD_X_W    = 6;
	localparam int COORD_Y_W    = 5;
	localparam int COLOR_W      = 24;
	localparam int CHAN_W       = 8;
	localparam int LED_INDEX_W  = 7;
	localparam int CFG_INDEX_W  = 2;
	localparam int CFG_DATA_W   = 2;

	// signed working width of the index arithmetic, wide enough for any
	// geometry in range (width up to 32, height up to 16, positions to 511)
	localparam int POS_W = 12;

	typedef logic signed [POS_W-1:0] pos_t;

	// configuration register indexes
	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_START_CORNER  = 2'd0,
		CFG_RUN_DIRECTION = 2'd1,
		CFG_LAYOUT_MODE   = 2'd2
	} cfg_index_t;

	// starting corner as seen on the register
	typedef enum logic [1:0] {
		CORNER_TOP_LEFT     = 2'd0,
		CORNER_TOP_RIGHT    = 2'd1,
		CORNER_BOTTOM_LEFT  = 2'd2,
		CORNER_BOTTOM_RIGHT = 2'd3
	} corner_t;

	// connection code of the strip's first LED
	typedef enum logic [1:0] {
		CONN_LEFT_BOTTOM  = 2'd0,
		CONN_LEFT_TOP     = 2'd1,
		CONN_RIGHT_TOP    = 2'd2,
		CONN_RIGHT_BOTTOM = 2'd3
	} conn_t;

	// run direction
	typedef enum logic [1:0] {
		DIR_RIGHT = 2'd0,
		DIR_UP    = 2'd1,
		DIR_LEFT  = 2'd2,
		DIR_DOWN  = 2'd3
	} dir_t;

	// wiring code: connection in bits 1..0, direction in bits 3..2
	typedef logic [3:0] wiring_t;

	localparam wiring_t WIRE_LB_UP    = {DIR_UP,    CONN_LEFT_BOTTOM};
	localparam wiring_t WIRE_LT_RIGHT = {DIR_RIGHT, CONN_LEFT_TOP};
	localparam wiring_t WIRE_LT_DOWN  = {DIR_DOWN,  CONN_LEFT_TOP};
	localparam wiring_t WIRE_RT_LEFT  = {DIR_LEFT,  CONN_RIGHT_TOP};
	localparam wiring_t WIRE_RT_DOWN  = {DIR_DOWN,  CONN_RIGHT_TOP};
	localparam wiring_t WIRE_RB_LEFT  = {DIR_LEFT,  CONN_RIGHT_BOTTOM};
	localparam wiring_t WIRE_RB_UP    = {DIR_UP,    CONN_RIGHT_BOTTOM};

	// layout mode
	localparam logic LAYOUT_ZIGZAG   = 1'b0;
	localparam logic LAYOUT_PARALLEL = 1'b1;

	// register reset values
	localparam logic [1:0] RST_START_CORNER  = CORNER_BOTTOM_LEFT;
	localparam logic [1:0] RST_RUN_DIRECTION = DIR_UP;
	localparam logic       RST_LAYOUT_MODE   = LAYOUT_ZIGZAG;

	// starting corner to connection code
	function automatic conn_t corner_to_conn(input logic [1:0] corner);
		conn_t conn;
		case (corner)
			CORNER_TOP_LEFT:     conn = CONN_LEFT_TOP;
			CORNER_TOP_RIGHT:    conn = CONN_RIGHT_TOP;
			CORNER_BOTTOM_LEFT:  conn = CONN_LEFT_BOTTOM;
			CORNER_BOTTOM_RIGHT: conn = CONN_RIGHT_BOTTOM;
			default:             conn = CONN_LEFT_BOTTOM;
		endcase
		return conn;
	endfunction

	// floor(c * b / 255), exact for every 16-bit product:
	// q = (p + (p >> 8) + 1) >> 8
	function automatic logic [CHAN_W-1:0] scale_channel(
		input logic [CHAN_W-1:0] c,
		input logic [CHAN_W-1:0] b
	);
		logic [2*CHAN_W-1:0] prod;
		logic [2*CHAN_W:0]   sum;
		prod = c * b;
		sum  = {1'b0, prod} + {{(CHAN_W+1){1'b0}}, prod[2*CHAN_W-1:CHAN_W]}
			+ {{(2*CHAN_W){1'b0}}, 1'b1};
		return sum[2*CHAN_W-1:CHAN_W];
	endfunction

endpackage

// File: sv/led_matrix_pixel_mapper_core.sv
// ----------------------------------------------------------------------------
// led_matrix_pixel_mapper_core
// Maps a pixel write on a serpentine- or parallel-wired LED matrix to its strip position
// and scales the colour channels by the brightness.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake                   | payload
//  ---------+-----------+-----------------------------+-------------------------
//  pixel    | in        | pixel_valid / pixel_stall   | coord_x coord_y color_word
//           |           |                             | brightness
//  result   | out       | result_valid / result_stall | accepted led_index red_out
//           |           |                             | green_out blue_out
//  cfg      | in        | cfg_valid / cfg_ready       | cfg_index cfg_data
//
// two register stages: input register, then the mapping and scaling logic
// into the result register. one pixel is taken every cycle while
// pixel_stall is low. pixel_stall rises only when both stages hold a
// transaction and result_stall is high. reset clears the valid flags and
// loads the register defaults; cfg_ready is always high.
//
module led_matrix_pixel_mapper_core
	import lmpm_pkg::*;
#(
	parameter int MATRIX_WIDTH  = DEF_MATRIX_WIDTH,
	parameter int MATRIX_HEIGHT = DEF_MATRIX_HEIGHT,
	parameter int LED_COUNT     = DEF_LED_COUNT
) (
	input  logic                          clk,
	input  logic                          arst_n,

	input  logic                          pixel_valid,
	output logic                          pixel_stall,
	input  logic signed [COORD_X_W-1:0]   coord_x,
	input  logic signed [COORD_Y_W-1:0]   coord_y,
	input  logic        [COLOR_W-1:0]     color_word,
	input  logic        [CHAN_W-1:0]      brightness,

	output logic                          result_valid,
	input  logic                          result_stall,
	output logic                          accepted,
	output logic        [LED_INDEX_W-1:0] led_index,
	output logic        [CHAN_W-1:0]      red_out,
	output logic        [CHAN_W-1:0]      green_out,
	output logic        [CHAN_W-1:0]      blue_out,

	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic        [CFG_INDEX_W-1:0] cfg_index,
	input  logic        [CFG_DATA_W-1:0]  cfg_data
);

	localparam pos_t W_P   = POS_W'(MATRIX_WIDTH);
	localparam pos_t H_P   = POS_W'(MATRIX_HEIGHT);
	localparam pos_t LC_P  = POS_W'(LED_COUNT);
	localparam pos_t ONE_P = POS_W'(1);

	// configuration registers
	logic [1:0] start_corner_q;
	logic [1:0] run_direction_q;
	logic       layout_mode_q;

	// stage 1: input register
	logic                        valid_s1;
	logic signed [COORD_X_W-1:0] coord_x_s1;
	logic signed [COORD_Y_W-1:0] coord_y_s1;
	logic        [COLOR_W-1:0]   color_s1;
	logic        [CHAN_W-1:0]    bright_s1;

	// stage 2: result register
	logic                   valid_s2;
	logic                   accepted_s2;
	logic [LED_INDEX_W-1:0] index_s2;
	logic [CHAN_W-1:0]      red_s2;
	logic [CHAN_W-1:0]      green_s2;
	logic [CHAN_W-1:0]      blue_s2;

	logic load_s1;
	logic load_s2;

	// mapping logic
	pos_t                   xs;
	pos_t                   ys;
	pos_t                   cx;
	pos_t                   cy;
	pos_t                   row_len;
	pos_t                   pos;
	wiring_t                wiring;
	logic                   in_range;
	logic [LED_INDEX_W-1:0] index_d;

	// flow control
	assign load_s2     = valid_s1 && (!valid_s2 || !result_stall);
	assign load_s1     = pixel_valid && !pixel_stall;
	assign pixel_stall = valid_s1 && !load_s2;
	assign cfg_ready   = 1'b1;

	// configuration writes, indexes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_corner_q  <= RST_START_CORNER;
			run_direction_q <= RST_RUN_DIRECTION;
			layout_mode_q   <= RST_LAYOUT_MODE;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_START_CORNER:  start_corner_q  <= cfg_data[1:0];
				CFG_RUN_DIRECTION: run_direction_q <= cfg_data[1:0];
				CFG_LAYOUT_MODE:   layout_mode_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= 1'b1;
		end else if (load_s2) begin
			valid_s1 <= 1'b0;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (load_s1) begin
			coord_x_s1 <= coord_x;
			coord_y_s1 <= coord_y;
			color_s1   <= color_word;
			bright_s1  <= brightness;
		end
	end

	// coordinates in working width and range check
	assign xs       = pos_t'(coord_x_s1);
	assign ys       = pos_t'(coord_y_s1);
	assign in_range = (xs >= 0) && (xs < W_P) && (ys >= 0) && (ys < H_P);
	assign wiring   = {run_direction_q, corner_to_conn(start_corner_q)};

	// axis swap and mirror per wiring
	always_comb begin
		cx      = xs;
		cy      = ys;
		row_len = W_P;
		case (wiring)
			WIRE_LB_UP: begin
				cx      = ys;
				cy      = xs;
				row_len = H_P;
			end
			WIRE_LT_RIGHT: begin
				cy = H_P - ys - ONE_P;
			end
			WIRE_LT_DOWN: begin
				cx      = H_P - ys - ONE_P;
				cy      = xs;
				row_len = H_P;
			end
			WIRE_RT_LEFT: begin
				cx = W_P - xs - ONE_P;
				cy = H_P - ys - ONE_P;
			end
			WIRE_RT_DOWN: begin
				cx      = H_P - ys - ONE_P;
				cy      = W_P - xs - ONE_P;
				row_len = H_P;
			end
			WIRE_RB_LEFT: begin
				cx = W_P - xs - ONE_P;
			end
			WIRE_RB_UP: begin
				cx      = ys;
				cy      = W_P - xs - ONE_P;
				row_len = H_P;
			end
			default: ;
		endcase
	end

	// strip position, odd rows reversed in zigzag layout
	always_comb begin
		if (layout_mode_q == LAYOUT_PARALLEL || !cy[0]) begin
			pos = cy * row_len + cx;
		end else begin
			pos = cy * row_len + (row_len - cx - ONE_P);
		end
		if (pos < 0 || pos >= LC_P) begin
			index_d = '0;
		end else begin
			index_d = pos[LED_INDEX_W-1:0];
		end
	end

	// stage 2 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= 1'b1;
		end else if (!result_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	// stage 2 payload, zero fields for an out-of-range pixel
	always_ff @(posedge clk) begin
		if (load_s2) begin
			accepted_s2 <= in_range;
			if (in_range) begin
				index_s2 <= index_d;
				red_s2   <= scale_channel(color_s1[23:16], bright_s1);
				green_s2 <= scale_channel(color_s1[15:8], bright_s1);
				blue_s2  <= scale_channel(color_s1[7:0], bright_s1);
			end else begin
				index_s2 <= '0;
				red_s2   <= '0;
				green_s2 <= '0;
				blue_s2  <= '0;
			end
		end
	end

	// result outputs
	assign result_valid = valid_s2;
	assign accepted     = accepted_s2;
	assign led_index    = index_s2;
	assign red_out      = red_s2;
	assign green_out    = green_s2;
	assign blue_out     = blue_s2;

endmodule

// File: tb/tb_led_matrix_pixel_mapper_core.sv
// ----------------------------------------------------------------------------
// tb_led_matrix_pixel_mapper_core
// Self-checking bench for the LED matrix pixel mapper. A directed table of
// pixel writes is followed by random writes under every corner, direction
// and layout setting. Each write is predicted in the bench and compared
// field by field against the result transactions, with random idling on
// both handshakes.
// ----------------------------------------------------------------------------
module tb_led_matrix_pixel_mapper_core;
	import lmpm_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MATRIX_WIDTH  = DEF_MATRIX_WIDTH;
	localparam int MATRIX_HEIGHT = DEF_MATRIX_HEIGHT;
	localparam int LED_COUNT     = DEF_LED_COUNT;

	localparam int CYCLE_LIMIT     = 200000;
	localparam int PHASE_COUNT     = 32;
	localparam int PIXELS_PER_PHASE = 43;
	localparam int DRAIN_CYCLES    = 4;

	// index past the end of the register file, writes to it are dropped
	localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_INDEX = 2'd3;

	typedef struct packed {
		logic                   acc;
		logic [LED_INDEX_W-1:0] idx;
		logic [CHAN_W-1:0]      red;
		logic [CHAN_W-1:0]      green;
		logic [CHAN_W-1:0]      blue;
	} led_result_t;

	typedef struct {
		int x;
		int y;
		int colour;
		int bright;
		bit typed;
		int acc;
		int idx;
		int red;
		int green;
		int blue;
	} pixel_row_t;

	localparam int DIRECTED_ROWS = 20;

	// directed writes under the reset wiring (bottom-left corner, running up, zigzag)
	pixel_row_t directed_pixels [DIRECTED_ROWS] = '{
		'{  0,   0, 24'hFFFFFF, 255, 1'b1, 1,   0, 255, 255, 255},
		'{ 15,   6, 24'hFFFFFF, 255, 1'b1, 1, 105, 255, 255, 255},
		'{  0,   6, 24'h000000, 255, 1'b1, 1,   6,   0,   0,   0},
		'{  1,   0, 24'hFFFFFF,   0, 1'b1, 1,  13,   0,   0,   0},
		'{  0,   0, 24'h000000,   0, 1'b1, 1,   0,   0,   0,   0},
		'{ -1,   0, 24'hFFFFFF, 255, 1'b1, 0,   0,   0,   0,   0},
		'{ 16,   3, 24'hFFFFFF, 255, 1'b1, 0,   0,   0,   0,   0},
		'{ 31,  15, 24'hFFFFFF, 255, 1'b1, 0,   0,   0,   0,   0},
		'{-32, -16, 24'hFFFFFF, 255, 1'b1, 0,   0,   0,   0,   0},
		'{  5,   7, 24'hFFFFFF, 255, 1'b1, 0,   0,   0,   0,   0},
		'{  5,  -1, 24'hFFFFFF, 255, 1'b1, 0,   0,   0,   0,   0},
		'{ 15,  15, 24'h123456, 200, 1'b1, 0,   0,   0,   0,   0},
		'{ 31,   6, 24'h654321,  17, 1'b1, 0,   0,   0,   0,   0},
		'{ 15,   0, 24'h123456, 128, 1'b0, 0,   0,   0,   0,   0},
		'{  7,   3, 24'hFF0000,   1, 1'b0, 0,   0,   0,   0,   0},
		'{  8,   4, 24'h00FF00, 254, 1'b0, 0,   0,   0,   0,   0},
		'{  3,   2, 24'h0000FF, 255, 1'b0, 0,   0,   0,   0,   0},
		'{  0,   0, 24'h808080, 127, 1'b0, 0,   0,   0,   0,   0},
		'{ 10,   5, 24'hAA55AA, 200, 1'b0, 0,   0,   0,   0,   0},
		'{ 14,   1, 24'h7F80FE,  85, 1'b0, 0,   0,   0,   0,   0}
	};

	logic                          clk          = 1'b0;
	logic                          arst_n       = 1'b0;
	logic                          pixel_valid  = 1'b0;
	logic                          pixel_stall;
	logic signed [COORD_X_W-1:0]   coord_x      = '0;
	logic signed [COORD_Y_W-1:0]   coord_y      = '0;
	logic        [COLOR_W-1:0]     color_word   = '0;
	logic        [CHAN_W-1:0]      brightness   = '0;
	logic                          result_valid;
	logic                          result_stall = 1'b0;
	logic                          accepted;
	logic        [LED_INDEX_W-1:0] led_index;
	logic        [CHAN_W-1:0]      red_out;
	logic        [CHAN_W-1:0]      green_out;
	logic        [CHAN_W-1:0]      blue_out;
	logic                          cfg_valid    = 1'b0;
	logic                          cfg_ready;
	logic        [CFG_INDEX_W-1:0] cfg_index    = '0;
	logic        [CFG_DATA_W-1:0]  cfg_data     = '0;

	// bench copy of the wiring registers
	logic [1:0] corner_reg = RST_START_CORNER;
	logic [1:0] dir_reg    = RST_RUN_DIRECTION;
	logic       layout_reg = RST_LAYOUT_MODE;

	led_result_t pending_leds [$];
	int          mismatch_count = 0;
	int          pixels_sent    = 0;
	int          results_seen   = 0;
	int          cycle_count    = 0;
	int          send_idle_pct  = 0;
	int          recv_idle_pct  = 0;

	led_matrix_pixel_mapper_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.pixel_valid  (pixel_valid),
		.pixel_stall  (pixel_stall),
		.coord_x      (coord_x),
		.coord_y      (coord_y),
		.color_word   (color_word),
		.brightness   (brightness),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.accepted     (accepted),
		.led_index    (led_index),
		.red_out      (red_out),
		.green_out    (green_out),
		.blue_out     (blue_out),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	// strip position and scaled colour of one pixel write
	function automatic led_result_t map_pixel(
		input logic signed [COORD_X_W-1:0] px,
		input logic signed [COORD_Y_W-1:0] py,
		input logic        [COLOR_W-1:0]   colour,
		input logic        [CHAN_W-1:0]    bright
	);
		led_result_t res;
		int          x;
		int          y;
		int          cx;
		int          cy;
		int          run_len;
		int          pos;
		conn_t       conn;
		wiring_t     code;
		res = '0;
		x   = px;
		y   = py;
		if (x < 0 || x >= MATRIX_WIDTH || y < 0 || y >= MATRIX_HEIGHT)
			return res;

		// corner of the first led as a connection code
		case (corner_reg)
			CORNER_TOP_LEFT:     conn = CONN_LEFT_TOP;
			CORNER_TOP_RIGHT:    conn = CONN_RIGHT_TOP;
			CORNER_BOTTOM_LEFT:  conn = CONN_LEFT_BOTTOM;
			default:             conn = CONN_RIGHT_BOTTOM;
		endcase
		code    = {dir_reg, conn};
		cx      = x;
		cy      = y;
		run_len = MATRIX_WIDTH;

		// axis swap and mirroring, untouched for unmapped wirings
		case (code)
			WIRE_LB_UP: begin
				cx = y; cy = x; run_len = MATRIX_HEIGHT;
			end
			WIRE_LT_RIGHT: begin
				cy = MATRIX_HEIGHT - y - 1;
			end
			WIRE_LT_DOWN: begin
				cx = MATRIX_HEIGHT - y - 1; cy = x; run_len = MATRIX_HEIGHT;
			end
			WIRE_RT_LEFT: begin
				cx = MATRIX_WIDTH - x - 1; cy = MATRIX_HEIGHT - y - 1;
			end
			WIRE_RT_DOWN: begin
				cx = MATRIX_HEIGHT - y - 1; cy = MATRIX_WIDTH - x - 1;
				run_len = MATRIX_HEIGHT;
			end
			WIRE_RB_LEFT: begin
				cx = MATRIX_WIDTH - x - 1;
			end
			WIRE_RB_UP: begin
				cx = y; cy = MATRIX_WIDTH - x - 1; run_len = MATRIX_HEIGHT;
			end
			default: ;
		endcase

		// odd rows run backwards in zigzag layout
		if (layout_reg == LAYOUT_PARALLEL || cy[0] == 1'b0)
			pos = cy * run_len + cx;
		else
			pos = cy * run_len + (run_len - cx - 1);
		if (pos < 0 || pos >= LED_COUNT)
			pos = 0;

		res.acc   = 1'b1;
		res.idx   = pos[LED_INDEX_W-1:0];
		res.red   = CHAN_W'((int'(colour[23:16]) * int'(bright)) / 255);
		res.green = CHAN_W'((int'(colour[15:8]) * int'(bright)) / 255);
		res.blue  = CHAN_W'((int'(colour[7:0]) * int'(bright)) / 255);
		return res;
	endfunction

	// present one pixel write and hold it until the transaction completes
	task automatic send_pixel(
		input int          x,
		input int          y,
		input int          colour,
		input int          bright,
		input bit          typed,
		input led_result_t typed_res
	);
		led_result_t want;
		if (typed)
			want = typed_res;
		else
			want = map_pixel(x[COORD_X_W-1:0], y[COORD_Y_W-1:0],
				colour[COLOR_W-1:0], bright[CHAN_W-1:0]);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			pixel_valid <= 1'b0;
			@(posedge clk);
		end
		pixel_valid <= 1'b1;
		coord_x     <= x[COORD_X_W-1:0];
		coord_y     <= y[COORD_Y_W-1:0];
		color_word  <= colour[COLOR_W-1:0];
		brightness  <= bright[CHAN_W-1:0];
		do
			@(posedge clk);
		while (!(pixel_valid && !pixel_stall));
		pending_leds.push_back(want);
		pixels_sent++;
	endtask

	// let every outstanding result come back, then settle the pipeline
	task automatic drain_pixels();
		pixel_valid <= 1'b0;
		while (pending_leds.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// one register write transaction
	task automatic write_reg(
		input logic [CFG_INDEX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0]  data
	);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (!(cfg_valid && cfg_ready));
		cfg_valid <= 1'b0;
		case (idx)
			CFG_START_CORNER:  corner_reg = data[1:0];
			CFG_RUN_DIRECTION: dir_reg    = data[1:0];
			CFG_LAYOUT_MODE:   layout_reg = data[0];
			default: ;
		endcase
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endtask

	// receiver back-pressure
	always @(posedge clk) begin
		result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
	end

	// compare each result transaction with the oldest prediction
	always @(posedge clk) begin : check_results
		led_result_t want;
		if (arst_n && result_valid && !result_stall) begin
			results_seen++;
			if (pending_leds.size() == 0) begin
				$error("result transaction with no pixel write outstanding");
				mismatch_count++;
			end else begin
				want = pending_leds.pop_front();
				check_field("accepted", want.acc, accepted);
				check_field("led_index", want.idx, led_index);
				check_field("red_out", want.red, red_out);
				check_field("green_out", want.green, green_out);
				check_field("blue_out", want.blue, blue_out);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// stimulus
	initial begin : stimulus
		led_result_t typed_res;
		int          x;
		int          y;
		int          bright;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table under the reset wiring
		send_idle_pct = 18;
		recv_idle_pct = 60;
		foreach (directed_pixels[i]) begin
			typed_res.acc   = directed_pixels[i].acc[0];
			typed_res.idx   = directed_pixels[i].idx[LED_INDEX_W-1:0];
			typed_res.red   = directed_pixels[i].red[CHAN_W-1:0];
			typed_res.green = directed_pixels[i].green[CHAN_W-1:0];
			typed_res.blue  = directed_pixels[i].blue[CHAN_W-1:0];
			send_pixel(directed_pixels[i].x, directed_pixels[i].y,
				directed_pixels[i].colour, directed_pixels[i].bright,
				directed_pixels[i].typed, typed_res);
		end

		// random writes, one phase per corner, direction and layout
		for (int ph = 0; ph < PHASE_COUNT; ph++) begin
			drain_pixels();
			if (ph < 11) begin
				send_idle_pct = 18;
				recv_idle_pct = 60;
			end else if (ph < 22) begin
				send_idle_pct = 60;
				recv_idle_pct = 18;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			write_reg(CFG_START_CORNER, ph[1:0]);
			write_reg(CFG_RUN_DIRECTION, ph[3:2]);
			write_reg(CFG_LAYOUT_MODE, {1'($urandom_range(0, 1)), ph[4]});
			if (ph % 8 == 3)
				write_reg(CFG_SPARE_INDEX, CFG_DATA_W'($urandom_range(0, 3)));

			for (int n = 0; n < PIXELS_PER_PHASE; n++) begin
				// mostly on-matrix pixels, the rest anywhere in the field
				if ($urandom_range(0, 99) < 80) begin
					x = $urandom_range(0, MATRIX_WIDTH - 1);
					y = $urandom_range(0, MATRIX_HEIGHT - 1);
				end else begin
					x = int'($urandom_range(0, 63)) - 32;
					y = int'($urandom_range(0, 31)) - 16;
				end
				case ($urandom_range(0, 9))
					0:       bright = 0;
					1:       bright = 255;
					default: bright = $urandom_range(0, 255);
				endcase
				send_pixel(x, y, $urandom_range(0, 24'hFFFFFF), bright, 1'b0, '0);
			end
		end

		drain_pixels();
		$display("%0d pixel writes over all 16 corner and direction pairs in both layouts,",
			pixels_sent);
		$display("%0d result transactions checked, %0d field mismatches",
			results_seen, mismatch_count);
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
